/* hdl/qba_pkg.sv */
// ----------------------------------------------------------------------------
// qba_pkg
// Shared widths, types and codes of the quadtree bin accumulator.
// ----------------------------------------------------------------------------
package qba_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int SUM_WIDTH  = 48;

  localparam int IDX_W      = 2 * MAX_LEVELS;
  localparam int CELLS      = 1 << IDX_W;
  localparam int COORD_W    = 32;
  // Coordinates grow by one bit per level, plus one for the edge sum.
  localparam int CW         = COORD_W + MAX_LEVELS + 1;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int LVL_REG_W  = 3;
  localparam int CNT_W      = 32;
  localparam int OUT_IDX_W  = 8;
  localparam int OUT_SUM_W  = 48;
  localparam int READ_IDX_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [COORD_W-1:0]  pos_t;
  typedef logic signed [CW-1:0]       coord_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic signed [SUM_WIDTH:0]   sum_ext_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam cnt_t CNT_MAX = '1;

  // Operation codes of the input item.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 3'd4;

  localparam pos_t X_LOW_RST  = 32'sd0;
  localparam pos_t X_HIGH_RST = 32'sd1048576;
  localparam pos_t Y_LOW_RST  = 32'sd0;
  localparam pos_t Y_HIGH_RST = 32'sd1048576;
  localparam logic [LVL_REG_W-1:0] LEVELS_RST = 3'd4;

  // One item on its way down the levels. Box edges are scaled by 2^k at
  // level k, the point by the same amount.
  typedef struct packed {
    logic             vld;
    logic             op;
    logic             drop;
    logic [LVL_W-1:0] left;
    logic [IDX_W-1:0] idx;
    coord_t           px;
    coord_t           py;
    coord_t           xl;
    coord_t           xh;
    coord_t           yl;
    coord_t           yh;
    pos_t             wt;
  } lvl_stage_t;

  typedef struct packed {
    logic             vld;
    logic             accepted;
    logic [IDX_W-1:0] idx;
    sum_t             sum;
    cnt_t             cnt;
  } cell_res_t;

endpackage

/* hdl/qba_if.sv */
// ----------------------------------------------------------------------------
// qba_in_if / qba_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface qba_in_if import qba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  pos_t                  x_pos;
  pos_t                  y_pos;
  pos_t                  weight;
  logic [READ_IDX_W-1:0] read_cell;

  modport source (output valid, operation, x_pos, y_pos, weight, read_cell,
                  input ready);
  modport sink   (input valid, operation, x_pos, y_pos, weight, read_cell,
                  output ready);
endinterface

interface qba_out_if import qba_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [OUT_IDX_W-1:0]        cell_index;
  logic signed [OUT_SUM_W-1:0] sum_out;
  logic [CNT_W-1:0]            count_out;

  modport source (output valid, accepted, cell_index, sum_out, count_out,
                  input ready);
  modport sink   (input valid, accepted, cell_index, sum_out, count_out,
                  output ready);
endinterface

/* hdl/qba_level.sv */
// ----------------------------------------------------------------------------
// qba_level
// One quadtree level: halves the box at its exact midpoint and picks the
// quadrant of the point, or flags the point when it sits on a midpoint.
// ----------------------------------------------------------------------------
module qba_level import qba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  lvl_stage_t d,
  output lvl_stage_t q
);

  lvl_stage_t q_r;
  lvl_stage_t q_nxt;
  coord_t     px2;
  coord_t     py2;
  coord_t     xm;
  coord_t     ym;
  logic       active;
  logic       qx;
  logic       qy;

  always_comb begin
    px2    = d.px <<< 1;
    py2    = d.py <<< 1;
    xm     = d.xl + d.xh;
    ym     = d.yl + d.yh;
    qx     = px2 > xm;
    qy     = py2 > ym;
    active = !d.drop && (d.left != '0);
    q_nxt  = d;
    if (active) begin
      q_nxt.px   = px2;
      q_nxt.py   = py2;
      q_nxt.left = d.left - 1'b1;
      if (px2 == xm || py2 == ym) begin
        q_nxt.drop = 1'b1;
      end else begin
        q_nxt.idx = (d.idx << 2) | IDX_W'({qy, qx});
        if (qx) begin
          q_nxt.xl = xm;
          q_nxt.xh = d.xh <<< 1;
        end else begin
          q_nxt.xl = d.xl <<< 1;
          q_nxt.xh = xm;
        end
        if (qy) begin
          q_nxt.yl = ym;
          q_nxt.yh = d.yh <<< 1;
        end else begin
          q_nxt.yl = d.yl <<< 1;
          q_nxt.yh = ym;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* hdl/qba_cell_store.sv */
// ----------------------------------------------------------------------------
// qba_cell_store
// Cell sum and count memories with a read-modify-write stage, forwarding of
// the write that lands on the same edge as a read, and per-cell valid bits.
// ----------------------------------------------------------------------------
module qba_cell_store import qba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  lvl_stage_t req,
  output cell_res_t  res
);

  sum_t             sum_mem [CELLS];
  cnt_t             cnt_mem [CELLS];
  logic [CELLS-1:0] init_r;

  sum_t             rd_sum_r;
  cnt_t             rd_cnt_r;
  logic             rd_init_r;
  lvl_stage_t       m_r;

  logic             fwd_vld_r;
  logic [IDX_W-1:0] fwd_idx_r;
  sum_t             fwd_sum_r;
  cnt_t             fwd_cnt_r;

  logic             rd_en;
  logic             wr_en;
  logic             fwd_hit;
  sum_t             cur_sum;
  sum_t             new_sum;
  cnt_t             cur_cnt;
  cnt_t             new_cnt;
  sum_ext_t         sum_wide;

  assign rd_en = adv && req.vld && !req.drop;
  assign wr_en = adv && m_r.vld && !m_r.drop && (m_r.op == OP_ADD);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sum_r  <= sum_mem[req.idx];
      rd_cnt_r  <= cnt_mem[req.idx];
      rd_init_r <= init_r[req.idx];
    end
    if (wr_en) begin
      sum_mem[m_r.idx] <= new_sum;
      cnt_mem[m_r.idx] <= new_cnt;
    end
  end

  // A cell that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (wr_en) begin
      init_r[m_r.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.vld   <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      m_r       <= req;
      fwd_vld_r <= wr_en;
      fwd_idx_r <= m_r.idx;
      fwd_sum_r <= new_sum;
      fwd_cnt_r <= new_cnt;
    end
  end

  always_comb begin
    // The memory read returns the old word when a write to the same cell
    // happens on the same edge, so that write is taken from the bypass.
    fwd_hit = fwd_vld_r && (fwd_idx_r == m_r.idx);
    if (fwd_hit) begin
      cur_sum = fwd_sum_r;
      cur_cnt = fwd_cnt_r;
    end else if (rd_init_r) begin
      cur_sum = rd_sum_r;
      cur_cnt = rd_cnt_r;
    end else begin
      cur_sum = '0;
      cur_cnt = '0;
    end

    sum_wide = sum_ext_t'(cur_sum) + sum_ext_t'(m_r.wt);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      new_sum = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = sum_wide[SUM_WIDTH-1:0];
    end
    new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

    res.vld = m_r.vld;
    if (m_r.drop) begin
      res.accepted = 1'b0;
      res.idx      = '0;
      res.sum      = '0;
      res.cnt      = '0;
    end else begin
      res.accepted = 1'b1;
      res.idx      = m_r.idx;
      res.sum      = (m_r.op == OP_ADD) ? new_sum : cur_sum;
      res.cnt      = (m_r.op == OP_ADD) ? new_cnt : cur_cnt;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_marks_cell: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> init_r[$past(m_r.idx)])
    else $error("written cell not marked valid");

  a_drop_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r.vld && m_r.drop) |-> (m_r.op == OP_ADD) && !wr_en)
    else $error("dropped item is a read or writes the store");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.accepted && (m_r.op == OP_ADD)) |-> (res.cnt != '0))
    else $error("binned point left a zero count");
`endif

endmodule

/* hdl/quadtree_bin_accumulator.sv */
// ----------------------------------------------------------------------------
// quadtree_bin_accumulator
// Bins weighted Q16.16 points into the leaf cells of a quadtree laid over a
// configurable rectangle, keeping a saturating sum and count per cell.
//
//   channel  direction  fields
//   in_ch    sink       operation, x_pos, y_pos, weight, read_cell
//   out_ch   source     accepted, cell_index, sum_out, count_out
//   cfg_*    write      cfg_we, cfg_index, cfg_data
//
// One item is taken every cycle unless the pipeline holds; a result passes
// through an entry register, one register per level, then the read-modify-write
// stage of the cell memory, then the output register.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the per-cell valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module quadtree_bin_accumulator import qba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  qba_in_if.sink                in_ch,
  qba_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pos_t                  x_low_r;
  pos_t                  x_high_r;
  pos_t                  y_low_r;
  pos_t                  y_high_r;
  logic [LVL_REG_W-1:0]  levels_r;

  logic                  adv;
  logic [LVL_W-1:0]      lv_use;
  lvl_stage_t            entry_nxt;
  lvl_stage_t            stage_s [MAX_LEVELS+1];
  cell_res_t             res;

  logic                  out_vld_r;
  logic                  out_acc_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic signed [OUT_SUM_W-1:0] out_sum_r;
  cnt_t                  out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= X_LOW_RST;
      x_high_r <= X_HIGH_RST;
      y_low_r  <= Y_LOW_RST;
      y_high_r <= Y_HIGH_RST;
      levels_r <= LEVELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:  x_low_r  <= cfg_data;
        CFG_X_HIGH: x_high_r <= cfg_data;
        CFG_Y_LOW:  y_low_r  <= cfg_data;
        CFG_Y_HIGH: y_high_r <= cfg_data;
        CFG_LEVELS: levels_r <= cfg_data[LVL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    if (levels_r > LVL_REG_W'(MAX_LEVELS)) begin
      lv_use = LVL_W'(MAX_LEVELS);
    end else begin
      lv_use = LVL_W'(levels_r);
    end

    entry_nxt.vld  = in_ch.valid;
    entry_nxt.op   = in_ch.operation;
    entry_nxt.drop = 1'b0;
    entry_nxt.px   = coord_t'(in_ch.x_pos);
    entry_nxt.py   = coord_t'(in_ch.y_pos);
    entry_nxt.xl   = coord_t'(x_low_r);
    entry_nxt.xh   = coord_t'(x_high_r);
    entry_nxt.yl   = coord_t'(y_low_r);
    entry_nxt.yh   = coord_t'(y_high_r);
    entry_nxt.wt   = in_ch.weight;
    // A read skips the descent and carries its cell index straight through.
    if (in_ch.operation == OP_READ) begin
      entry_nxt.left = '0;
      entry_nxt.idx  = IDX_W'(in_ch.read_cell);
    end else begin
      entry_nxt.left = lv_use;
      entry_nxt.idx  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_s[0].vld <= 1'b0;
    end else if (adv) begin
      stage_s[0] <= entry_nxt;
    end
  end

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
    qba_level u_level (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d     (stage_s[k]),
      .q     (stage_s[k+1])
    );
  end

  qba_cell_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (stage_s[MAX_LEVELS]),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
      out_acc_r <= res.accepted;
      out_idx_r <= OUT_IDX_W'(res.idx);
      out_sum_r <= OUT_SUM_W'(res.sum);
      out_cnt_r <= res.cnt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.cell_index = out_idx_r;
  assign out_ch.sum_out    = out_sum_r;
  assign out_ch.count_out  = out_cnt_r;

endmodule
